/* sv/nearest_point_match_wrapped_angle_assert.svh */
// Assertion helpers for the nearest point match block.
`ifndef NEAREST_POINT_MATCH_WRAPPED_ANGLE_ASSERT_SVH
`define NEAREST_POINT_MATCH_WRAPPED_ANGLE_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define NPM_ASSERT(lbl, clk_s, rst_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);
`define NPM_ASSERT_NEVER(lbl, clk_s, rst_s, expr, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) !(expr)) else $error(msg);
`else
`define NPM_ASSERT(lbl, clk_s, rst_s, prop, msg)
`define NPM_ASSERT_NEVER(lbl, clk_s, rst_s, expr, msg)
`endif

`endif

/* sv/npm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package npm_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 64;

    localparam int ETA_W     = 16;
    localparam int PHI_W     = 14;
    localparam int IDX_OUT_W = 6;
    localparam int DIST_W    = 31;
    localparam int DE_W      = 16;   // |eta difference|
    localparam int WRAP_W    = 13;   // wrapped |phi difference|, at most pi
    localparam int SQ_E_W    = 2 * DE_W;
    localparam int SQ_W_W    = 2 * WRAP_W;
    localparam int SQ_W      = SQ_E_W + 1;

    localparam logic signed [15:0] TWO_PI_Q11 = 16'sd12868;
    localparam logic [DIST_W-1:0]  DIST_MAX   = {DIST_W{1'b1}};

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_QUERY  = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic signed [ETA_W-1:0] eta;
        logic signed [PHI_W-1:0] phi;
    } point_t;

    typedef struct packed {
        logic valid;
        logic first;
    } scan_ctrl_t;

endpackage

`default_nettype wire

/* sv/nearest_point_match_wrapped_angle.sv */
`timescale 1ns / 1ps
`default_nettype none
// Nearest reference point search with wrapped azimuth.
// Requests come in on the s_ group: tuser carries the action (clear, append,
// query), tdata the point. Clear and append give no
// result. A query gives one result on the m_ group: the index of the closest
// stored point (first on ties), its squared distance saturated to 31 bits,
// and in tuser a flag set when the table was empty.
// Points sit in a ring of TABLE_DEPTH cells. A query rotates the ring once
// through a three stage distance unit at its head; a query on an empty
// table skips the scan and goes straight to the result. One request is
// worked on at a time; s_tready is high only while the block is idle.
// The result sits in an output register: a new request is accepted while it
// waits, and a later query holds its result until m_tready frees the
// register. Reset empties the table; stored points need no clearing since
// only entries below the count are ever compared.
`include "nearest_point_match_wrapped_angle_assert.svh"

module nearest_point_match_wrapped_angle
    import npm_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // eta[15:0], phi[29:16], zero pad
    input  wire logic [1:0]  s_tuser,   // action[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // nearest_index[5:0], dist_sq[36:6], zero pad
    output logic             m_tuser    // table_empty[0]
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W = IDX_W + 1;

    state_t state_reg, state_next;

    logic [CNT_W-1:0] entry_count_reg, entry_count_next;
    logic [IDX_W-1:0] scan_reg, scan_next;
    point_t           query_reg;
    logic             empty_reg;
    logic             m_tvalid_reg;
    logic [39:0]      m_tdata_reg;
    logic             m_tuser_reg;

    logic             accept;
    logic             shift;
    logic             out_load;
    logic             scan_last;
    scan_ctrl_t       feed;
    point_t           in_pt;
    point_t           pts [TABLE_DEPTH];

    logic             busy;
    logic [SQ_W-1:0]  best_sq;
    logic [IDX_W-1:0] best_idx;
    logic [IDX_W+IDX_OUT_W-1:0] idx_ext;
    logic [DIST_W-1:0] dist_sat;

    assign in_pt.eta = s_tdata[ETA_W-1:0];
    assign in_pt.phi = s_tdata[ETA_W+PHI_W-1:ETA_W];
    assign accept    = s_tvalid && s_tready;
    assign scan_last = (scan_reg == IDX_W'(TABLE_DEPTH - 1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && (s_tuser == ACT_QUERY))
                begin
                    state_next = (entry_count_reg == '0) ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!busy)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        s_tready   = 1'b0;
        shift      = 1'b0;
        out_load   = 1'b0;
        feed.valid = 1'b0;
        feed.first = 1'b0;
        unique case (state_reg)
            ST_IDLE:   s_tready = 1'b1;
            ST_SCAN:
            begin
                shift      = 1'b1;
                feed.valid = ({1'b0, scan_reg} < CMP_W'(entry_count_reg));
                feed.first = (scan_reg == '0);
            end
            ST_DRAIN:  ;
            ST_FINISH: out_load = !m_tvalid_reg || m_tready;
            default:   ;
        endcase
    end

    always_comb
    begin
        entry_count_next = entry_count_reg;
        if (accept)
        begin
            case (s_tuser)
                ACT_CLEAR:  entry_count_next = '0;
                ACT_APPEND:
                begin
                    if (entry_count_reg < CNT_W'(TABLE_DEPTH))
                    begin
                        entry_count_next = entry_count_reg + CNT_W'(1);
                    end
                end
                default:    ;
            endcase
        end
        scan_next = shift ? (scan_last ? '0 : scan_reg + IDX_W'(1)) : scan_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            entry_count_reg <= '0;
            scan_reg        <= '0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            entry_count_reg <= entry_count_next;
            scan_reg        <= scan_next;
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign idx_ext  = {{IDX_OUT_W{1'b0}}, best_idx};
    assign dist_sat = (best_sq > SQ_W'(DIST_MAX)) ? DIST_MAX : best_sq[DIST_W-1:0];

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            query_reg <= in_pt;
            empty_reg <= (entry_count_reg == '0);
        end
        if (out_load)
        begin
            if (empty_reg)
            begin
                m_tdata_reg <= '0;
                m_tuser_reg <= 1'b1;
            end
            else
            begin
                m_tdata_reg <= {3'b000, dist_sat, idx_ext[IDX_OUT_W-1:0]};
                m_tuser_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // ring of cells: cell i takes cell i+1, so entry k reaches the head after k shifts
    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_ring
        localparam int NXT = (i + 1) % TABLE_DEPTH;
        logic load_i;

        assign load_i = accept && (s_tuser == ACT_APPEND)
                        && (entry_count_reg == CNT_W'(i));

        npm_cell u_cell (
            .clk     (clk),
            .load    (load_i),
            .shift   (shift),
            .load_pt (in_pt),
            .nbr_pt  (pts[NXT]),
            .pt      (pts[i])
        );
    end

    npm_dist #(
        .IDX_W (IDX_W)
    ) u_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (feed),
        .idx      (scan_reg),
        .query    (query_reg),
        .ref_pt   (pts[0]),
        .busy     (busy),
        .best_sq  (best_sq),
        .best_idx (best_idx)
    );

    `NPM_ASSERT(a_count_bound, clk, rst_n, entry_count_reg <= CNT_W'(TABLE_DEPTH), "count overflow")
    `NPM_ASSERT(a_scan_to_drain, clk, rst_n, (state_reg == ST_SCAN) && scan_last |=> (state_reg == ST_DRAIN) && (scan_reg == '0), "ring not back in place after scan")
    `NPM_ASSERT(a_empty_zero, clk, rst_n, m_tvalid && m_tuser |-> (m_tdata == '0), "empty result with data")
    `NPM_ASSERT_NEVER(a_finish_busy, clk, rst_n, (state_reg == ST_FINISH) && busy, "result taken while distance unit busy")

endmodule

`default_nettype wire

/* sv/npm_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module npm_cell
    import npm_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   load,
    input  wire logic   shift,
    input  wire point_t load_pt,
    input  wire point_t nbr_pt,
    output point_t      pt
);

    point_t pt_reg;
    point_t pt_next;

    always_comb
    begin
        pt_next = pt_reg;
        if (load)
        begin
            pt_next = load_pt;
        end
        else if (shift)
        begin
            pt_next = nbr_pt;
        end
    end

    always_ff @(posedge clk)
    begin
        pt_reg <= pt_next;
    end

    assign pt = pt_reg;

endmodule

`default_nettype wire

/* sv/npm_dist.sv */
`timescale 1ns / 1ps
`default_nettype none

module npm_dist
    import npm_pkg::*;
#(
    parameter int IDX_W = 6
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire scan_ctrl_t       ctrl,
    input  wire logic [IDX_W-1:0] idx,
    input  wire point_t           query,
    input  wire point_t           ref_pt,
    output logic                  busy,
    output logic [SQ_W-1:0]       best_sq,
    output logic [IDX_W-1:0]      best_idx
);

    // stage A: absolute differences, phi wrapped at two pi
    logic                 va_reg, va_next;
    logic                 fa_reg;
    logic [IDX_W-1:0]     ia_reg;
    logic [DE_W-1:0]      de_reg, de_next;
    logic [WRAP_W-1:0]    w_reg, w_next;

    // stage B: squares
    logic                 vb_reg;
    logic                 fb_reg;
    logic [IDX_W-1:0]     ib_reg;
    logic [SQ_E_W-1:0]    sqe_reg;
    logic [SQ_W_W-1:0]    sqw_reg;

    // stage C: running minimum
    logic [SQ_W-1:0]      best_sq_reg, best_sq_next;
    logic [IDX_W-1:0]     best_idx_reg, best_idx_next;
    logic [SQ_W-1:0]      sum;

    logic signed [ETA_W:0] de_s;
    logic signed [PHI_W:0] dp_s;
    logic [PHI_W-1:0]      dp_abs;
    logic signed [15:0]    dp_ext;
    logic signed [15:0]    alt;
    logic [15:0]           alt_abs;

    always_comb
    begin
        de_s    = {query.eta[ETA_W-1], query.eta} - {ref_pt.eta[ETA_W-1], ref_pt.eta};
        de_next = de_s[ETA_W] ? DE_W'(-de_s) : DE_W'(de_s);
        dp_s    = {query.phi[PHI_W-1], query.phi} - {ref_pt.phi[PHI_W-1], ref_pt.phi};
        dp_abs  = dp_s[PHI_W] ? PHI_W'(-dp_s) : PHI_W'(dp_s);
        dp_ext  = $signed({2'b00, dp_abs});
        alt     = TWO_PI_Q11 - dp_ext;
        alt_abs = alt[15] ? 16'(-alt) : 16'(alt);
        if (dp_ext < alt)
        begin
            w_next = WRAP_W'(dp_abs);
        end
        else
        begin
            w_next = WRAP_W'(alt_abs);
        end
        va_next = ctrl.valid;
    end

    always_comb
    begin
        sum           = {1'b0, sqe_reg} + SQ_W'(sqw_reg);
        best_sq_next  = best_sq_reg;
        best_idx_next = best_idx_reg;
        if (vb_reg && (fb_reg || (sum < best_sq_reg)))
        begin
            best_sq_next  = sum;
            best_idx_next = ib_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            va_reg <= va_next;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        fa_reg       <= ctrl.first;
        ia_reg       <= idx;
        de_reg       <= de_next;
        w_reg        <= w_next;
        fb_reg       <= fa_reg;
        ib_reg       <= ia_reg;
        sqe_reg      <= SQ_E_W'(de_reg) * SQ_E_W'(de_reg);
        sqw_reg      <= SQ_W_W'(w_reg) * SQ_W_W'(w_reg);
        best_sq_reg  <= best_sq_next;
        best_idx_reg <= best_idx_next;
    end

    assign busy     = va_reg | vb_reg;
    assign best_sq  = best_sq_reg;
    assign best_idx = best_idx_reg;

endmodule

`default_nettype wire

/* verif/nearest_point_match_wrapped_angle_test.sv */
`timescale 1ns / 1ps

module nearest_point_match_wrapped_angle_test;
    import npm_pkg::*;

    localparam int DEPTH          = DEFAULT_TABLE_DEPTH;
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam longint PHI_TURN   = 12868;   // two pi in Q4.11
    localparam int RANDOM_ITEMS   = 1880;
    localparam int MAX_GAP        = 12;
    localparam int HOLD_CYCLES    = 300;
    localparam int HOLD_AT        = 600;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 80;
    localparam int MAX_PRINTED    = 40;

    typedef struct packed {
        logic [1:0]              act;
        logic signed [ETA_W-1:0] eta;
        logic signed [PHI_W-1:0] phi;
        logic                    pinned;   // row carries its own expected result
        logic [IDX_OUT_W-1:0]    idx;
        logic [DIST_W-1:0]       dist_sq;
        logic                    empty;
    } point_req_t;

    typedef struct packed {
        logic [IDX_OUT_W-1:0] idx;
        logic [DIST_W-1:0]    dist_sq;
        logic                 empty;
    } match_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        m_tuser;

    nearest_point_match_wrapped_angle uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    point_req_t directed_rows [0:24] = '{
        '{ACT_QUERY,  16'sd0,      14'sd0,     1'b1, 6'd0, 31'd0,    1'b1}, // empty after reset
        '{ACT_UNUSED, 16'sd1234,   -14'sd99,   1'b0, 6'd0, 31'd0,    1'b0},
        '{ACT_QUERY,  16'sd5,      14'sd5,     1'b1, 6'd0, 31'd0,    1'b1},
        '{ACT_APPEND, 16'sd0,      14'sd0,     1'b0, 6'd0, 31'd0,    1'b0},
        '{ACT_QUERY,  16'sd0,      14'sd0,     1'b1, 6'd0, 31'd0,    1'b0},
        '{ACT_APPEND, 16'sd20480,  14'sd6434,  1'b0, 6'd0, 31'd0,    1'b0},
        '{ACT_APPEND, -16'sd20480, -14'sd6434, 1'b0, 6'd0, 31'd0,    1'b0},
        '{ACT_APPEND, 16'sd0,      14'sd0,     1'b0, 6'd0, 31'd0,    1'b0},
        '{ACT_QUERY,  16'sd20480,  -14'sd6434, 1'b0, 6'd0, 31'd0,    1'b0}, // wraps at pi
        '{ACT_QUERY,  -16'sd20480, 14'sd6434,  1'b0, 6'd0, 31'd0,    1'b0},
        '{ACT_QUERY,  16'sd0,      14'sd0,     1'b1, 6'd0, 31'd0,    1'b0}, // tie, first kept
        '{ACT_QUERY,  16'sd100,    14'sd3000,  1'b0, 6'd0, 31'd0,    1'b0},
        '{ACT_UNUSED, 16'sd0,      14'sd0,     1'b0, 6'd0, 31'd0,    1'b0},
        '{ACT_QUERY,  16'sd20480,  14'sd6434,  1'b1, 6'd1, 31'd0,    1'b0},
        '{ACT_CLEAR,  16'sd0,      14'sd0,     1'b0, 6'd0, 31'd0,    1'b0},
        '{ACT_QUERY,  16'sd0,      14'sd0,     1'b1, 6'd0, 31'd0,    1'b1},
        '{ACT_APPEND, 16'sd32767,  14'sd0,     1'b0, 6'd0, 31'd0,    1'b0},
        '{ACT_QUERY,  16'h8000,    14'sd0,     1'b1, 6'd0, DIST_MAX, 1'b0}, // saturates
        '{ACT_APPEND, 16'sd0,      14'h2000,   1'b0, 6'd0, 31'd0,    1'b0},
        '{ACT_QUERY,  16'sd0,      14'h1FFF,   1'b0, 6'd0, 31'd0,    1'b0}, // phi off range
        '{ACT_QUERY,  16'h8000,    14'h1FFF,   1'b0, 6'd0, 31'd0,    1'b0},
        '{ACT_CLEAR,  16'sd0,      14'sd0,     1'b0, 6'd0, 31'd0,    1'b0},
        '{ACT_APPEND, -16'sd1,     -14'sd1,    1'b0, 6'd0, 31'd0,    1'b0},
        '{ACT_QUERY,  16'hFFFF,    14'h3FFF,   1'b1, 6'd0, 31'd0,    1'b0},
        '{ACT_CLEAR,  16'sd0,      14'sd0,     1'b0, 6'd0, 31'd0,    1'b0}
    };

    // predictor state
    logic signed [ETA_W-1:0] tbl_eta [DEPTH];
    logic signed [PHI_W-1:0] tbl_phi [DEPTH];
    int tbl_count = 0;

    point_req_t plan_q [$];
    match_t     match_q [$];
    point_req_t offered;
    match_t     got_match;
    match_t     want_match;
    bit         got_answers;

    bit hold_off_pending = 0;
    bit hold_done = 0;
    int n_bad = 0;
    int n_results = 0;
    int n_requests = 0;
    int n_empty = 0;
    int n_sat = 0;
    int n_full_drops = 0;
    int stuck_cycles = 0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
    end

    function automatic longint unsigned wrapped_dist_sq(
        input logic signed [ETA_W-1:0] eta_a, input logic signed [PHI_W-1:0] phi_a,
        input logic signed [ETA_W-1:0] eta_b, input logic signed [PHI_W-1:0] phi_b);
        longint de;
        longint dp;
        longint alt;
        longint w;
        de = longint'(eta_a) - longint'(eta_b);
        dp = longint'(phi_a) - longint'(phi_b);
        if (dp < 0)
            dp = -dp;
        alt = PHI_TURN - dp;
        w = (dp < alt) ? dp : alt;
        // alt goes negative only for phi beyond +-pi; it is squared anyway
        if (w < 0)
            w = -w;
        if (de < 0)
            de = -de;
        return longint'(de * de + w * w);
    endfunction

    task automatic apply_point_request(input point_req_t r, output bit answers,
                                       output match_t m);
        longint unsigned ds;
        longint unsigned best;
        int best_i;
        answers = 1'b0;
        m = '0;
        case (r.act)
            ACT_CLEAR:
                tbl_count = 0;
            ACT_APPEND:
            begin
                if (tbl_count < DEPTH)
                begin
                    tbl_eta[tbl_count] = r.eta;
                    tbl_phi[tbl_count] = r.phi;
                    tbl_count++;
                end
                else
                    n_full_drops++;
            end
            ACT_QUERY:
            begin
                answers = 1'b1;
                if (tbl_count == 0)
                    m.empty = 1'b1;
                else
                begin
                    best = 0;
                    best_i = 0;
                    for (int i = 0; i < tbl_count; i++)
                    begin
                        ds = wrapped_dist_sq(r.eta, r.phi, tbl_eta[i], tbl_phi[i]);
                        if (i == 0 || ds < best)
                        begin
                            best = ds;
                            best_i = i;
                        end
                    end
                    m.idx = best_i[IDX_OUT_W-1:0];
                    m.dist_sq = (best > DIST_MAX) ? DIST_MAX : best[DIST_W-1:0];
                end
            end
            default: ;
        endcase
    endtask

    task automatic note_mismatch(input string what, input longint unsigned seen,
                                 input longint unsigned want);
        n_bad++;
        if (n_bad <= MAX_PRINTED)
            $display("mismatch at result %0d: %s got %0d, want %0d",
                     n_results, what, seen, want);
    endtask

    function automatic void pick_point(input int style, output logic signed [ETA_W-1:0] e,
                                       output logic signed [PHI_W-1:0] p);
        int ei;
        int pi_v;
        case (style)
            0:
            begin
                ei = int'($urandom_range(0, 40960)) - 20480;
                pi_v = int'($urandom_range(0, 12868)) - 6434;
            end
            1:
            begin
                // tight cluster, lots of equal distances
                ei = int'($urandom_range(0, 16)) - 8;
                pi_v = int'($urandom_range(0, 16)) - 8;
            end
            2:
            begin
                // hugging +-pi so the wrap decides
                ei = int'($urandom_range(0, 64)) - 32;
                pi_v = 6434 - int'($urandom_range(0, 40));
                if ($urandom_range(0, 1) == 1)
                    pi_v = -pi_v;
            end
            default:
            begin
                ei = int'($urandom);
                pi_v = int'($urandom);
            end
        endcase
        e = ei[ETA_W-1:0];
        p = pi_v[PHI_W-1:0];
    endfunction

    function automatic void push_req(input logic [1:0] act, input logic signed [ETA_W-1:0] e,
                                     input logic signed [PHI_W-1:0] p);
        point_req_t r;
        r = '0;
        r.act = act;
        r.eta = e;
        r.phi = p;
        plan_q = {plan_q, r};
    endfunction

    // Mostly clear / fill / query runs with random content, some raw noise.
    task automatic build_random_requests();
        int n_live;
        int fill;
        int style;
        int sel;
        int j;
        logic [1:0] act;
        logic signed [ETA_W-1:0] e;
        logic signed [PHI_W-1:0] p;
        logic signed [ETA_W-1:0] kept_eta [$];
        logic signed [PHI_W-1:0] kept_phi [$];
        n_live = 0;
        while (n_live < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                if ($urandom_range(0, 4) != 0 || kept_eta.size() >= DEPTH)
                begin
                    push_req(ACT_CLEAR, '0, '0);
                    kept_eta.delete();
                    kept_phi.delete();
                    n_live++;
                end
                sel = $urandom_range(0, 9);
                if (sel < 7)
                    fill = $urandom_range(1, 8);
                else if (sel < 9)
                    fill = $urandom_range(9, 63);
                else
                    fill = $urandom_range(64, 70);   // runs past a full table
                style = $urandom_range(0, 3);
                repeat (fill)
                begin
                    pick_point(style, e, p);
                    push_req(ACT_APPEND, e, p);
                    if (kept_eta.size() < DEPTH)
                    begin
                        kept_eta = {kept_eta, e};
                        kept_phi = {kept_phi, p};
                        n_live++;
                    end
                end
                repeat ($urandom_range(1, 6))
                begin
                    if (kept_eta.size() > 0 && $urandom_range(0, 4) < 2)
                    begin
                        j = $urandom_range(0, kept_eta.size() - 1);
                        e = kept_eta[j];
                        p = kept_phi[j];
                    end
                    else
                        pick_point(($urandom_range(0, 3) == 0) ? 3 : style, e, p);
                    push_req(ACT_QUERY, e, p);
                    n_live++;
                end
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                begin
                    act = 2'($urandom_range(0, 3));
                    push_req(act, ETA_W'($urandom), PHI_W'($urandom));
                    if (act != ACT_UNUSED)
                        n_live++;
                end
            end
        end
    endtask

    // scoreboard: results checked first, then the accepted request predicted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                n_results++;
                if (match_q.size() == 0)
                    note_mismatch("result with none pending, nearest_index",
                                  m_tdata[IDX_OUT_W-1:0], 0);
                else
                begin
                    want_match = match_q.pop_front();
                    if (m_tdata[IDX_OUT_W-1:0] !== want_match.idx)
                        note_mismatch("nearest_index", m_tdata[IDX_OUT_W-1:0], want_match.idx);
                    if (m_tdata[IDX_OUT_W +: DIST_W] !== want_match.dist_sq)
                        note_mismatch("dist_sq", m_tdata[IDX_OUT_W +: DIST_W],
                                      want_match.dist_sq);
                    if (m_tuser !== want_match.empty)
                        note_mismatch("table_empty", m_tuser, want_match.empty);
                    if (want_match.empty)
                        n_empty++;
                    if (want_match.dist_sq == DIST_MAX)
                        n_sat++;
                end
            end
            if (s_tvalid && s_tready)
            begin
                n_requests++;
                apply_point_request(offered, got_answers, got_match);
                if (got_answers)
                begin
                    if (offered.pinned)
                    begin
                        got_match.idx = offered.idx;
                        got_match.dist_sq = offered.dist_sq;
                        got_match.empty = offered.empty;
                    end
                    match_q = {match_q, got_match};
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stuck_cycles <= 0;
        else
        begin
            stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles == WATCHDOG_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles, %0d results pending",
                         WATCHDOG_LIMIT, match_q.size());
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // receiver: random stalls, bursts of none, one long hold-off
    initial
    begin : result_side
        int stall;
        int taken;
        m_tready = 1'b0;
        taken = 0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (hold_off_pending)
            begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_off_pending = 0;
                hold_done = 1;
            end
            stall = (((taken / 20) % 5) == 2) ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0)
            begin
                m_tready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready = 1'b1;
            do @(posedge clk); while (!m_tvalid);
            taken++;
            @(negedge clk);
        end
    end

    initial
    begin : request_side
        int gap;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        offered = '0;
        foreach (directed_rows[i])
            plan_q = {plan_q, directed_rows[i]};
        build_random_requests();
        wait (rst_n === 1'b1);
        @(negedge clk);
        for (int k = 0; k < plan_q.size(); k++)
        begin
            gap = (((k / 50) % 5) == 4) ? 0 : $urandom_range(0, MAX_GAP);
            if (k == HOLD_AT)
                hold_off_pending = 1;
            if (gap > 0)
            begin
                s_tvalid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            offered = plan_q[k];
            s_tuser = offered.act;
            s_tdata = {2'b00, offered.phi, offered.eta};
            s_tvalid = 1'b1;
            do @(posedge clk); while (!s_tready);
            @(negedge clk);
        end
        s_tvalid = 1'b0;
        while (match_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("%0d requests sent, %0d query results checked (%0d on an empty table, %0d saturated)",
                 n_requests, n_results, n_empty, n_sat);
        $display("%0d appends dropped on a full table, long output hold-off done: %0d",
                 n_full_drops, hold_done);
        if (n_bad == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
